// ===== sv/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and constants of the timeout deadline scheduler.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int TIME_W   = 64;
  localparam int CLIENT_W = 6;
  localparam int NPT_W    = 10;
  localparam int FUNC_W   = 2;
  localparam int KIND_W   = 2;

  // Reset value of the nanoseconds-per-tick register (50 MHz clock).
  localparam logic [NPT_W-1:0] NS_PER_TICK_RESET = 10'd20;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  // Result codes.
  localparam logic [KIND_W-1:0] KIND_TIME   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECALC,
    ST_ACT,
    ST_POP
  } state_t;

  // One pending deadline.
  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [CLIENT_W-1:0] owner;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                ins;
    logic                pop;
    logic [TIME_W-1:0]   key;
    logic [CLIENT_W-1:0] owner;
  } cell_ctl_t;

endpackage

// ===== sv/tds_if.sv =====
// ----------------------------------------------------------------------------
// tds_if
// Valid/ready channels of the timeout deadline scheduler.
// ----------------------------------------------------------------------------
interface tds_in_if;
  logic                          valid;
  logic                          ready;
  logic [tds_pkg::FUNC_W-1:0]    func;
  logic [tds_pkg::CLIENT_W-1:0]  client;
  logic [tds_pkg::TIME_W-1:0]    delay_ns;

  modport source (output valid, func, client, delay_ns, input ready);
  modport sink   (input valid, func, client, delay_ns, output ready);
endinterface

interface tds_out_if;
  logic                          valid;
  logic                          ready;
  logic [tds_pkg::KIND_W-1:0]    kind;
  logic [tds_pkg::CLIENT_W-1:0]  target;
  logic [tds_pkg::TIME_W-1:0]    time_ns;
  logic                          last;

  modport source (output valid, kind, target, time_ns, last, input ready);
  modport sink   (input valid, kind, target, time_ns, last, output ready);
endinterface

interface tds_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tds_pkg::NPT_W-1:0]     ns_per_tick;

  modport source (output valid, ns_per_tick, input ready);
  modport sink   (input valid, ns_per_tick, output ready);
endinterface

// ===== sv/tds_cell.sv =====
// ----------------------------------------------------------------------------
// tds_cell
// One slot of the sorted deadline chain.
// ----------------------------------------------------------------------------
module tds_cell (
  input  logic               clk,
  input  tds_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  tds_pkg::entry_t    left_entry,
  input  logic               left_gt,
  input  tds_pkg::entry_t    right_entry,
  output tds_pkg::entry_t    entry,
  output logic               gt
);

  tds_pkg::entry_t entry_r;
  tds_pkg::entry_t entry_nxt;

  // An empty slot, or one whose deadline is later than the key, lies behind
  // the new entry. Equal deadlines stay ahead so ties keep insertion order.
  assign gt    = !occ || (entry_r.deadline > ctl.key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.pop) begin
      entry_nxt = right_entry;
    end else if (ctl.ins && gt) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else begin
        entry_nxt.deadline = ctl.key;
        entry_nxt.owner    = ctl.owner;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== sv/timeout_deadline_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// timeout_deadline_scheduler_core
// Tick counter with a sorted chain of pending client deadlines.
// ----------------------------------------------------------------------------
// The block counts ticks and reports time in nanoseconds as the tick count
// times ns_per_tick, modulo 2^64. Deadlines live in a chain of QUEUE_DEPTH
// cells kept sorted by deadline; an insert shifts the later cells right by
// one all at once, and an expiry pops the head by shifting left. An item is
// accepted, then acted on (reply, reject or insert), then its due
// expiries are delivered one by one until nothing more is due; stalls on
// the result channel hold the reply, rejection and expiries. The running
// time is kept by an adder, so a write of ns_per_tick is followed by a
// recalc state in which the time is recomputed with a 64 by 10 bit
// multiplier and no item is taken.
// After every item all deadlines at or below the current time are delivered
// earliest first, and the final result of an item carries last.
module timeout_deadline_scheduler_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  tds_in_if.sink        in_ch,
  tds_out_if.source     out_ch,
  tds_cfg_if.sink       cfg_ch
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tds_pkg::state_t state_r, state_nxt;

  logic [tds_pkg::TIME_W-1:0]   tick_r, tick_nxt;
  logic [tds_pkg::TIME_W-1:0]   time_r, time_nxt;
  logic [tds_pkg::NPT_W-1:0]    npt_r, npt_nxt;
  logic [CW-1:0]                count_r, count_nxt;

  // Request captured at acceptance.
  logic [tds_pkg::FUNC_W-1:0]   func_r;
  logic [tds_pkg::CLIENT_W-1:0] client_r;
  logic [tds_pkg::TIME_W-1:0]   offset_r;

  // Result register.
  logic                         out_valid_r, out_valid_nxt;
  logic [tds_pkg::KIND_W-1:0]   out_kind_r;
  logic [tds_pkg::CLIENT_W-1:0] out_target_r;
  logic [tds_pkg::TIME_W-1:0]   out_time_r;
  logic                         out_last_r;

  logic [tds_pkg::TIME_W+tds_pkg::NPT_W-1:0] prod;

  logic in_fire, cfg_fire, out_free, full, head_due, second_due;
  logic emit;
  logic [tds_pkg::KIND_W-1:0]   emit_kind;
  logic [tds_pkg::CLIENT_W-1:0] emit_target;
  logic                         emit_last;
  logic act_emit, act_ins, pop_fire;

  tds_pkg::cell_ctl_t           ctl;
  tds_pkg::entry_t              entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]       gts;
  logic [QUEUE_DEPTH-1:0]       occs;

  // --------------------------------------------------------------------------
  // Handshakes. Configuration takes precedence over an item in the idle state.
  // --------------------------------------------------------------------------
  assign cfg_ch.ready = (state_r == tds_pkg::ST_IDLE);
  assign in_ch.ready  = (state_r == tds_pkg::ST_IDLE) && !cfg_ch.valid;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_due   = occs[0] && (entries[0].deadline <= time_r);
  assign second_due = occs[1] && (entries[1].deadline <= time_r);

  // --------------------------------------------------------------------------
  // The cell chain. Each cell sees its left neighbor for inserts and its right
  // neighbor for pops.
  // --------------------------------------------------------------------------
  assign ctl.ins   = act_ins;
  assign ctl.pop   = pop_fire;
  assign ctl.key   = time_r + offset_r;
  assign ctl.owner = client_r;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tds_pkg::entry_t left_e, right_e;
    logic            left_g;

    assign occs[i] = (count_r > CW'(i));

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_rest
      assign left_e = entries[i-1];
      assign left_g = gts[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    tds_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occs[i]),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .entry       (entries[i]),
      .gt          (gts[i])
    );
  end

  // --------------------------------------------------------------------------
  // Control decisions shared by the next-state and output logic.
  // --------------------------------------------------------------------------
  always_comb begin
    act_emit = 1'b0;
    act_ins  = 1'b0;
    pop_fire = 1'b0;
    if (state_r == tds_pkg::ST_ACT) begin
      if (func_r == tds_pkg::FUNC_GET) begin
        act_emit = out_free;
      end else if (func_r == tds_pkg::FUNC_SET) begin
        act_emit = full && out_free;
        act_ins  = !full;
      end
    end
    if (state_r == tds_pkg::ST_POP) begin
      pop_fire = head_due && out_free;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tds_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          state_nxt = tds_pkg::ST_RECALC;
        end else if (in_fire && (in_ch.func != tds_pkg::FUNC_NONE)) begin
          state_nxt = tds_pkg::ST_ACT;
        end
      end
      tds_pkg::ST_RECALC: begin
        state_nxt = tds_pkg::ST_IDLE;
      end
      tds_pkg::ST_ACT: begin
        // A reply or rejection waits until the result register is free.
        if (act_emit || act_ins || (func_r == tds_pkg::FUNC_TICK)) begin
          state_nxt = tds_pkg::ST_POP;
        end
      end
      tds_pkg::ST_POP: begin
        if (!head_due) begin
          state_nxt = tds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tds_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine: which result, if any, is loaded.
  always_comb begin
    emit        = 1'b0;
    emit_kind   = tds_pkg::KIND_TIME;
    emit_target = '0;
    emit_last   = 1'b0;
    unique case (state_r)
      tds_pkg::ST_ACT: begin
        emit      = act_emit;
        emit_last = !head_due;
        if (func_r == tds_pkg::FUNC_SET) begin
          emit_kind   = tds_pkg::KIND_REJECT;
          emit_target = client_r;
        end
      end
      tds_pkg::ST_POP: begin
        emit        = pop_fire;
        emit_kind   = tds_pkg::KIND_EXPIRY;
        emit_target = entries[0].owner;
        emit_last   = !second_due;
      end
      tds_pkg::ST_IDLE, tds_pkg::ST_RECALC: begin
        emit = 1'b0;
      end
      default: emit = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Time, counter and configuration.
  // --------------------------------------------------------------------------
  assign prod = tick_r * npt_r;

  always_comb begin
    tick_nxt  = tick_r;
    time_nxt  = time_r;
    npt_nxt   = npt_r;
    count_nxt = count_r;
    if (cfg_fire) begin
      npt_nxt = cfg_ch.ns_per_tick;
    end
    if (state_r == tds_pkg::ST_RECALC) begin
      time_nxt = prod[tds_pkg::TIME_W-1:0];
    end
    if (in_fire && (in_ch.func == tds_pkg::FUNC_TICK)) begin
      tick_nxt = tick_r + 64'd1;
      time_nxt = time_r + {{(tds_pkg::TIME_W-tds_pkg::NPT_W){1'b0}}, npt_r};
    end
    if (act_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_fire) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tds_pkg::ST_IDLE;
      tick_r      <= '0;
      time_r      <= '0;
      npt_r       <= tds_pkg::NS_PER_TICK_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      time_r      <= time_nxt;
      npt_r       <= npt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_ch.func;
      client_r <= in_ch.client;
      offset_r <= in_ch.delay_ns;
    end
    if (emit) begin
      out_kind_r   <= emit_kind;
      out_target_r <= emit_target;
      out_time_r   <= time_r;
      out_last_r   <= emit_last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.kind    = out_kind_r;
  assign out_ch.target  = out_target_r;
  assign out_ch.time_ns = out_time_r;
  assign out_ch.last    = out_last_r;

endmodule

// ===== sim/tds_schedule_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tds_schedule_monitor
// Watches the request, result and setup channels of the deadline scheduler,
// keeps its own copy of the tick count and the pending deadlines, and checks
// every result the block delivers against the results it owes.
// ----------------------------------------------------------------------------
module tds_schedule_monitor #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  tds_in_if    in_ch,
  tds_out_if   out_ch,
  tds_cfg_if   cfg_ch,
  output int   errors,
  output int   backlog,
  output int   items_seen,
  output int   results_seen,
  output int   expiries_seen,
  output int   rejects_seen
);
  import tds_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CLIENT_W-1:0] target;
    logic [TIME_W-1:0]   time_ns;
    logic                last;
  } notice_t;

  logic [TIME_W-1:0]   ticks;
  logic [NPT_W-1:0]    scale;
  logic [TIME_W-1:0]   due_at    [QUEUE_DEPTH];
  logic [CLIENT_W-1:0] due_owner [QUEUE_DEPTH];
  int                  pending;
  notice_t             owed_results[$];

  function automatic void owe(logic [KIND_W-1:0] kind, logic [CLIENT_W-1:0] who,
                              logic [TIME_W-1:0] now);
    notice_t n;
    n.kind    = kind;
    n.target  = who;
    n.time_ns = now;
    n.last    = 1'b0;
    owed_results.push_back(n);
  endfunction

  // Applies one request to the shadow state and queues the results it causes.
  function automatic void serve_request(logic [FUNC_W-1:0] func, logic [CLIENT_W-1:0] client,
                                        logic [TIME_W-1:0] offset);
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] when;
    int                first;
    int                pos;
    int                n_due;
    int                i;
    notice_t           tail;
    if (func == FUNC_NONE) return;
    first = owed_results.size();
    if (func == FUNC_TICK) ticks = ticks + 1;
    now = ticks * TIME_W'(scale);

    if (func == FUNC_GET) begin
      owe(KIND_TIME, '0, now);
    end else if (func == FUNC_SET) begin
      if (pending >= QUEUE_DEPTH) begin
        owe(KIND_REJECT, client, now);
      end else begin
        // Stable insert: equal deadlines keep their arrival order.
        when = now + offset;
        pos  = 0;
        while (pos < pending && due_at[pos] <= when) pos++;
        for (i = pending; i > pos; i--) begin
          due_at[i]    = due_at[i-1];
          due_owner[i] = due_owner[i-1];
        end
        due_at[pos]    = when;
        due_owner[pos] = client;
        pending++;
      end
    end

    n_due = 0;
    while (n_due < pending && due_at[n_due] <= now) begin
      owe(KIND_EXPIRY, due_owner[n_due], now);
      n_due++;
    end
    for (i = 0; i + n_due < pending; i++) begin
      due_at[i]    = due_at[i+n_due];
      due_owner[i] = due_owner[i+n_due];
    end
    pending -= n_due;

    if (owed_results.size() > first) begin
      tail      = owed_results.pop_back();
      tail.last = 1'b1;
      owed_results.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin : watch
    notice_t want;
    notice_t got;
    if (!rst_n) begin
      ticks   = '0;
      scale   = NS_PER_TICK_RESET;
      pending = 0;
      owed_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind    = out_ch.kind;
        got.target  = out_ch.target;
        got.time_ns = out_ch.time_ns;
        got.last    = out_ch.last;
        results_seen++;
        if (got.kind == KIND_EXPIRY) expiries_seen++;
        if (got.kind == KIND_REJECT) rejects_seen++;
        if (owed_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result: kind %0d target %0d time %0d last %0d",
                     $realtime, got.kind, got.target, got.time_ns, got.last);
        end else begin
          want = owed_results.pop_front();
          if (got.kind !== want.kind || got.target !== want.target ||
              got.time_ns !== want.time_ns || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] result mismatch: expected kind %0d target %0d time %0d last %0d",
                       $realtime, want.kind, want.target, want.time_ns, want.last);
              $display("          actual            kind %0d target %0d time %0d last %0d",
                       got.kind, got.target, got.time_ns, got.last);
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) scale = cfg_ch.ns_per_tick;
      if (in_ch.valid && in_ch.ready) begin
        items_seen++;
        serve_request(in_ch.func, in_ch.client, in_ch.delay_ns);
      end
    end
    backlog = owed_results.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for timeout_deadline_scheduler_core.
// A short directed sequence walks through the corner cases of the scheduler:
// an unused request code, time replies, zero and wrapping offsets, equal
// deadlines, a full deadline set and its rejection. Six phases of random
// requests follow, each at its own ns_per_tick setting and one of five
// pacing patterns, with bursts that fill the set and one long hold on the
// result side. A separate monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  import tds_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 42;
  // The slowest legal run is far below this limit, even with a few hundred
  // items each causing the full seventeen results behind an 87 percent stall.
  localparam int CYCLE_LIMIT = 400_000;

  // Per-phase setup: tick scale and the percentage of cycles in which the
  // sender idles and the receiver stalls. The last phase draws its scale.
  localparam int PHASE_NPT [PHASES] = '{20, 1, 1000, 0, 1023, 0};
  localparam int PHASE_TX  [PHASES] = '{0, 87, 0, 13, 0, 13};
  localparam int PHASE_RX  [PHASES] = '{0, 0, 87, 13, 0, 87};

  logic clk = 1'b0;
  logic rst_n;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_left    = 0;
  int npt_now      = NS_PER_TICK_RESET;
  int cycle_count  = 0;

  int errors;
  int backlog;
  int items_seen;
  int results_seen;
  int expiries_seen;
  int rejects_seen;

  tds_in_if  in_ch ();
  tds_out_if out_ch ();
  tds_cfg_if cfg_ch ();

  timeout_deadline_scheduler_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tds_schedule_monitor #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) i_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .errors        (errors),
    .backlog       (backlog),
    .items_seen    (items_seen),
    .results_seen  (results_seen),
    .expiries_seen (expiries_seen),
    .rejects_seen  (rejects_seen)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout_deadline_scheduler_core regression: fail");
      $finish;
    end
  end

  // Result side. The ready line changes only at falling edges. A long hold
  // requested by the stimulus is counted down here, one cycle per falling
  // edge; otherwise the line stalls at the rate of the current phase.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offers one request item. Entered and left at a falling edge; valid stays
  // high on return so that back-to-back items need no extra assignment. While
  // the sender idles, the payload lines carry noise that must be ignored.
  task automatic offer_item(input logic [FUNC_W-1:0] func, input logic [CLIENT_W-1:0] client,
                            input logic [TIME_W-1:0] offset);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid    <= 1'b0;
      in_ch.func     <= FUNC_W'($urandom);
      in_ch.client   <= CLIENT_W'($urandom);
      in_ch.delay_ns <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= func;
    in_ch.client   <= client;
    in_ch.delay_ns <= offset;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // One random request. Most offsets are a few ticks long at the current
  // scale so that deadlines come due during the phase; some are zero, some
  // wrap below the present time, and a rare one is a full 64-bit value.
  task automatic random_item();
    int                pick;
    int                shape;
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] offset;
    pick  = $urandom_range(99);
    shape = $urandom_range(99);
    if (pick < 38)      func = FUNC_TICK;
    else if (pick < 52) func = FUNC_GET;
    else if (pick < 96) func = FUNC_SET;
    else                func = FUNC_NONE;
    if (func != FUNC_SET)
      offset = {$urandom, $urandom};
    else if (shape < 8)
      offset = '0;
    else if (shape < 16)
      offset = ~TIME_W'($urandom_range(0, 5000));
    else if (shape < 17)
      offset = {$urandom, $urandom};
    else
      offset = TIME_W'($urandom_range(0, 8)) * TIME_W'(npt_now) +
               TIME_W'($urandom_range(0, npt_now + 3));
    offer_item(func, CLIENT_W'($urandom_range(63)), offset);
  endtask

  // Seventeen set requests with one shared offset: fills the deadline set,
  // produces rejections and long runs of equal deadlines. The extra
  // nanosecond keeps the entries pending even when the scale is zero.
  task automatic fill_burst();
    logic [TIME_W-1:0] offset;
    offset = TIME_W'($urandom_range(2, 6)) * TIME_W'(npt_now) + 1;
    repeat (QUEUE_DEPTH + 1) offer_item(FUNC_SET, CLIENT_W'($urandom_range(63)), offset);
  endtask

  // Brings the block to rest: no owed results and enough cycles for a
  // request that causes no result to pass through its three internal steps.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_scale(input logic [NPT_W-1:0] value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.ns_per_tick <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    npt_now = value;
  endtask

  initial begin : stimulus
    int               p;
    int               k;
    int               burst_at;
    logic [NPT_W-1:0] scale;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_TICK;
    in_ch.client       <= '0;
    in_ch.delay_ns     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.ns_per_tick <= NS_PER_TICK_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk at the reset scale of 20 ns per tick.
    // The unused request code must leave no trace.
    offer_item(FUNC_NONE, 6'd63, '1);
    // Time reply at time zero.
    offer_item(FUNC_GET, 6'd0, '0);
    // A zero offset expires within the same item.
    offer_item(FUNC_SET, 6'd5, '0);
    offer_item(FUNC_TICK, 6'd0, '0);
    // An all-ones offset wraps to just below the present time: due at once.
    offer_item(FUNC_SET, 6'd63, '1);
    // Two equal deadlines and an earlier one inserted after them.
    offer_item(FUNC_SET, 6'd1, 64'd40);
    offer_item(FUNC_SET, 6'd2, 64'd40);
    offer_item(FUNC_SET, 6'd3, 64'd20);
    offer_item(FUNC_SET, 6'd0, 64'd0);
    // Three entries are pending; thirteen more fill the set and the last
    // request is turned away.
    for (k = 0; k < QUEUE_DEPTH - 2; k++)
      offer_item(FUNC_SET, CLIENT_W'(10 + k), 64'd1000);
    // Client 3 expires first, then clients 1 and 2 in their arrival order.
    offer_item(FUNC_TICK, 6'd0, '0);
    offer_item(FUNC_TICK, 6'd0, '0);
    offer_item(FUNC_GET, 6'd62, '1);
    settle();

    // Random phases. The scale is only rewritten with the block at rest.
    for (p = 0; p < PHASES; p++) begin
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      scale = (p == PHASES - 1) ? NPT_W'($urandom_range(2, 999)) : NPT_W'(PHASE_NPT[p]);
      write_scale(scale);
      tx_idle_pct  = PHASE_TX[p];
      rx_stall_pct = PHASE_RX[p];
      // The new scale moves the time without an item, so the first item of
      // a phase can carry a reply or rejection followed by expiries.
      offer_item($urandom_range(1) ? FUNC_GET : FUNC_SET,
                 CLIENT_W'($urandom_range(63)), TIME_W'($urandom_range(3)));
      burst_at = $urandom_range(5, PHASE_ITEMS - QUEUE_DEPTH - 5);
      k = 1;
      while (k < PHASE_ITEMS) begin
        if (k == burst_at) begin
          fill_burst();
          k += QUEUE_DEPTH + 1;
        end else begin
          random_item();
          k++;
        end
      end

      // Back pressure: the receiver holds off for a long stretch while the
      // sender keeps offering requests, so a result waits in the result register
      // and the block stops taking requests.
      if (p == 4) begin
        hold_left = 300;
        for (k = 0; k < 30; k++)
          offer_item((k % 2) ? FUNC_TICK : FUNC_GET, CLIENT_W'($urandom_range(63)),
                     {$urandom, $urandom});
      end
      settle();
    end

    repeat (16) @(negedge clk);
    $display("Checked %0d results (%0d expiries, %0d rejections) from %0d items",
             results_seen, expiries_seen, rejects_seen, items_seen);
    $display("over six tick scales, five pacing patterns and one long output hold.");
    if (errors == 0 && backlog == 0) begin
      $display("timeout_deadline_scheduler_core regression: pass");
    end else begin
      $display("timeout_deadline_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule
